@@ rtl/core/dmc_pkg.sv @@
// ----------------------------------------------------------------------------
// dmc_pkg - direct-mapped cache tag check, shared definitions
// Field widths of the item ports and the default geometry of the tag store.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam int ADDR_W         = 32;  // byte address
  localparam int OFFSET_W       = 2;   // byte within line
  localparam int TAG_OUT_W      = 16;  // tag field on the result port
  localparam int LINE_OUT_W     = 14;  // line index field on the result port
  localparam int CNT_W          = 16;  // hit / miss counters, wrapping
  localparam int INDEX_BITS_DEF = 14;  // default line index width

endpackage

@@ rtl/core/direct_mapped_cache_tag_check.sv @@
// Path: an accepted item's address and stored tag word are registered at its accepting
// edge; the result is registered onto out_* once the output register is free.
// Flow: one item at a time (tag memory read, then compare and write back).
// Reset: synchronous, active low; clears counters and control, then a clearing pass
// over all 2**INDEX_BITS lines (16384 at default) zeroes every valid bit; in_ready stays
// low throughout the pass.
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_check - tag lookup for a direct-mapped cache
// Splits each byte address into tag, line index and byte offset, checks the
// line's valid bit and stored tag, allocates the line on a miss and keeps
// wrapping hit and miss counts.
// ----------------------------------------------------------------------------
module direct_mapped_cache_tag_check
  import dmc_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF  // 4 .. 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADDR_W-1:0]     in_address,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic [TAG_OUT_W-1:0]  out_tag,
  output logic [LINE_OUT_W-1:0] out_line_index,
  output logic [OFFSET_W-1:0]   out_byte_offset,
  output logic [CNT_W-1:0]      out_hit_count,
  output logic [CNT_W-1:0]      out_miss_count
);

  // Geometry. Tag is everything above the index; memory word is {valid, tag}.
  localparam int LINES = 1 << INDEX_BITS;
  localparam int TAG_W = ADDR_W - INDEX_BITS - OFFSET_W;
  localparam int MEM_W = TAG_W + 1;

  // Controller: clearing pass after reset, then normal running.
  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN   = 1'b1;

  logic                  state_r,   state_nxt;
  logic [INDEX_BITS-1:0] clr_idx_r, clr_idx_nxt;
  logic                  busy_r,    busy_nxt;     // an item is in flight, not yet completed
  logic [ADDR_W-1:0]     addr_r;                  // address of the item in flight
  logic [CNT_W-1:0]      hit_cnt_r,  hit_cnt_nxt;
  logic [CNT_W-1:0]      miss_cnt_r, miss_cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Output payload register
  logic                  out_hit_r;
  logic [TAG_OUT_W-1:0]  out_tag_r;
  logic [LINE_OUT_W-1:0] out_line_r;
  logic [OFFSET_W-1:0]   out_off_r;
  logic [CNT_W-1:0]      out_hcnt_r;
  logic [CNT_W-1:0]      out_mcnt_r;

  // Tag memory ports
  logic [MEM_W-1:0]      mem [LINES];
  logic                  rd_en;
  logic [INDEX_BITS-1:0] rd_addr;
  logic [MEM_W-1:0]      rd_data_r;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_addr;
  logic [MEM_W-1:0]      wr_data;

  // Lookup of the item in flight
  logic                  accept;
  logic                  complete;
  logic [TAG_W-1:0]      req_tag;
  logic [INDEX_BITS-1:0] req_idx;
  logic                  hit;
  logic [ADDR_W-1:0]     tag_ext;
  logic [ADDR_W-1:0]     idx_ext;

  assign in_ready = (state_r == ST_RUN) && !busy_r;
  assign accept   = in_valid && in_ready;

  assign req_tag  = addr_r[ADDR_W-1 -: TAG_W];
  assign req_idx  = addr_r[OFFSET_W +: INDEX_BITS];
  // stored word: top bit valid, rest tag; full-width tag compare
  assign hit      = rd_data_r[MEM_W-1] && (rd_data_r[TAG_W-1:0] == req_tag);

  // Finish only when the output register can take the result; the read data
  // holds meanwhile, as no new read is issued while busy.
  assign complete = busy_r && (!out_valid_r || out_ready);

  // Fields truncate to the port widths, zero-extended first for narrow cases
  assign tag_ext  = ADDR_W'(req_tag);
  assign idx_ext  = ADDR_W'(req_idx);

  // Memory port control. A miss writes back in the completing cycle; the next
  // read is issued no earlier than the following cycle, so it sees the update.
  always_comb begin
    rd_en   = accept;
    rd_addr = in_address[OFFSET_W +: INDEX_BITS];
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
      wr_data = '0;
    end else begin
      wr_en   = complete && !hit;
      wr_addr = req_idx;
      wr_data = {1'b1, req_tag};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    busy_nxt      = busy_r;
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    out_valid_nxt = out_valid_r;

    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (&clr_idx_r) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (accept) begin
          busy_nxt = 1'b1;
        end else if (complete) begin
          busy_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    if (complete) begin
      if (hit) begin
        hit_cnt_nxt = hit_cnt_r + 1'b1;
      end else begin
        miss_cnt_nxt = miss_cnt_r + 1'b1;
      end
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      busy_r      <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      busy_r      <= busy_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_address;
    end
    if (complete) begin
      out_hit_r  <= hit;
      out_tag_r  <= tag_ext[TAG_OUT_W-1:0];
      out_line_r <= idx_ext[LINE_OUT_W-1:0];
      out_off_r  <= addr_r[OFFSET_W-1:0];
      out_hcnt_r <= hit_cnt_nxt;
      out_mcnt_r <= miss_cnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_tag         = out_tag_r;
  assign out_line_index  = out_line_r;
  assign out_byte_offset = out_off_r;
  assign out_hit_count   = out_hcnt_r;
  assign out_miss_count  = out_mcnt_r;

endmodule

@@ dv/direct_mapped_cache_tag_check_checker.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_check_checker - lookup predictor and result checker
// Watches both item channels. Each accepted address is looked up in a private
// copy of the tag store. Each returned item is compared field by field, in
// order, against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module direct_mapped_cache_tag_check_checker
  import dmc_pkg::*;
#(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_hit,
  input  logic [TAG_OUT_W-1:0]  out_tag,
  input  logic [LINE_OUT_W-1:0] out_line_index,
  input  logic [OFFSET_W-1:0]   out_byte_offset,
  input  logic [CNT_W-1:0]      out_hit_count,
  input  logic [CNT_W-1:0]      out_miss_count,
  output int unsigned           errors,
  output int unsigned           pending
);

  localparam int LINES = 1 << INDEX_BITS;

  typedef struct packed {
    logic                  hit;
    logic [TAG_OUT_W-1:0]  tag;
    logic [LINE_OUT_W-1:0] line_index;
    logic [OFFSET_W-1:0]   byte_offset;
    logic [CNT_W-1:0]      hit_count;
    logic [CNT_W-1:0]      miss_count;
  } lookup_t;

  logic [ADDR_W-1:0] stored_tag [LINES];
  bit   [LINES-1:0]  line_live;
  logic [CNT_W-1:0]  hits_seen;
  logic [CNT_W-1:0]  misses_seen;
  lookup_t           lookups_due [$];
  int unsigned       results_seen;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < 100) begin
      $display("MISMATCH item %0d %s: got %0h expected %0h", results_seen, what, got, want);
    end
    errors++;
  endtask

  // full-width tag is kept per line; counters wrap naturally at CNT_W
  function automatic lookup_t predict_lookup(input logic [ADDR_W-1:0] addr);
    logic [INDEX_BITS-1:0] line_no;
    logic [ADDR_W-1:0]     tag_no;
    lookup_t               r;
    line_no = addr[OFFSET_W +: INDEX_BITS];
    tag_no  = addr >> (OFFSET_W + INDEX_BITS);
    r.hit   = line_live[line_no] && (stored_tag[line_no] == tag_no);
    if (r.hit) begin
      hits_seen++;
    end else begin
      stored_tag[line_no] = tag_no;
      line_live[line_no]  = 1'b1;
      misses_seen++;
    end
    r.tag         = tag_no[TAG_OUT_W-1:0];
    r.line_index  = LINE_OUT_W'(line_no);
    r.byte_offset = addr[OFFSET_W-1:0];
    r.hit_count   = hits_seen;
    r.miss_count  = misses_seen;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lookup_t want;
    if (!rst_n) begin
      line_live    = '0;
      hits_seen    = '0;
      misses_seen  = '0;
      results_seen = 0;
      errors       = 0;
      lookups_due.delete();
    end else begin
      // results first: an item accepted at this edge cannot already be out
      if (out_valid && out_ready) begin
        if (lookups_due.size() == 0) begin
          report_mismatch("with no lookup outstanding, tag", 32'(out_tag), '0);
        end else begin
          want = lookups_due.pop_front();
          if (out_hit !== want.hit) begin
            report_mismatch("hit", 32'(out_hit), 32'(want.hit));
          end
          if (out_tag !== want.tag) begin
            report_mismatch("tag", 32'(out_tag), 32'(want.tag));
          end
          if (out_line_index !== want.line_index) begin
            report_mismatch("line_index", 32'(out_line_index), 32'(want.line_index));
          end
          if (out_byte_offset !== want.byte_offset) begin
            report_mismatch("byte_offset", 32'(out_byte_offset), 32'(want.byte_offset));
          end
          if (out_hit_count !== want.hit_count) begin
            report_mismatch("hit_count", 32'(out_hit_count), 32'(want.hit_count));
          end
          if (out_miss_count !== want.miss_count) begin
            report_mismatch("miss_count", 32'(out_miss_count), 32'(want.miss_count));
          end
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        lookups_due.push_back(predict_lookup(in_address));
      end
    end
    pending <= lookups_due.size();
  end

endmodule

@@ dv/direct_mapped_cache_tag_check_test.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_check_test - top of the tag check testbench
// Drives byte addresses into the block and drains its result items with random
// gaps on both sides. A short directed run covers corner addresses, eviction
// and re-allocation; a random run with hot lines and conflicting tags follows.
// The checker beside the block predicts and compares; this module only gives
// the verdict.
// ----------------------------------------------------------------------------
module direct_mapped_cache_tag_check_test;
  import dmc_pkg::*;

  // Run limit covers the valid-bit clearing pass after reset, ~965 items with both
  // sides idling at random and the long hold-off, then several times over.
  localparam int unsigned RUN_LIMIT    = 200_000;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned HOLD_OFF     = 400;    // receiver stall in cycles
  localparam int unsigned HOLD_AT      = 60;     // result number that triggers it
  localparam int unsigned TAIL         = 20;     // plenty of margin after the last result

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [ADDR_W-1:0]     in_address = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic                  out_hit;
  logic [TAG_OUT_W-1:0]  out_tag;
  logic [LINE_OUT_W-1:0] out_line_index;
  logic [OFFSET_W-1:0]   out_byte_offset;
  logic [CNT_W-1:0]      out_hit_count;
  logic [CNT_W-1:0]      out_miss_count;

  int unsigned       errors;
  int unsigned       pending;
  int unsigned       cycles  = 0;
  int unsigned       tx_calm = 0;
  logic [ADDR_W-1:0] hot_addr [16];    // working set for the random run

  always #5 clk = ~clk;

  direct_mapped_cache_tag_check i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_tag         (out_tag),
    .out_line_index  (out_line_index),
    .out_byte_offset (out_byte_offset),
    .out_hit_count   (out_hit_count),
    .out_miss_count  (out_miss_count)
  );

  direct_mapped_cache_tag_check_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hit         (out_hit),
    .out_tag         (out_tag),
    .out_line_index  (out_line_index),
    .out_byte_offset (out_byte_offset),
    .out_hit_count   (out_hit_count),
    .out_miss_count  (out_miss_count),
    .errors          (errors),
    .pending         (pending)
  );

  // Random idle cycles before the next item. Now and then a calm stretch of
  // several items with no idling at all, so back-to-back traffic is seen too.
  function automatic int unsigned pick_wait(inout int unsigned calm);
    if (calm != 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
    end
    return $urandom_range(0, 11);
  endfunction

  // Offer one address and hold it until the block takes it.
  task automatic send_item(input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = pick_wait(tx_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Random address with cache-like locality: mostly re-touches of a hot line
  // (hits), some conflicting tags on a hot line (evictions), some accesses to
  // the first and last lines, and the rest uniform over the whole space.
  function automatic logic [ADDR_W-1:0] next_address();
    int unsigned       k;
    int unsigned       pick;
    logic [ADDR_W-1:0] a;
    k    = $urandom_range(0, 15);
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      hot_addr[k] = $urandom();
    end
    a = hot_addr[k];
    if (pick < 10) begin
      a[1:0] = 2'($urandom_range(0, 3));
    end else if (pick < 14) begin
      a[31:16] = 16'($urandom());
    end else if (pick < 16) begin
      a       = $urandom();
      a[15:2] = ($urandom_range(0, 1) != 0) ? 14'h3fff : 14'h0000;
    end else begin
      a = $urandom();
    end
    return a;
  endfunction

  // Watchdog: also catches a block that never leaves its clearing pass.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side. Random back-pressure per item; one long hold-off, counted
  // here, while the sender keeps offering so the block fills and stalls.
  initial begin : drain
    int unsigned gap;
    int unsigned got;
    int unsigned calm;
    got  = 0;
    calm = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = pick_wait(calm);
      if (got == HOLD_AT) begin
        gap = HOLD_OFF;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      got++;
    end
  end

  initial begin : stimulus
    int unsigned n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: untouched line, re-hit, eviction on line 0 and on the last
    // line, tag and offset extremes, alternating bit patterns.
    send_item(32'h0000_0000);  // never-written line: miss
    send_item(32'h0000_0000);  // hit
    send_item(32'h0000_0003);  // hit, top offset
    send_item(32'hffff_0000);  // top tag evicts line 0
    send_item(32'h0000_0001);  // old tag gone: miss again
    send_item(32'hffff_ffff);  // last line, all ones
    send_item(32'hffff_fffe);  // hit
    send_item(32'h0000_fffc);  // last line, tag zero: evicts
    send_item(32'hffff_fffd);  // miss after eviction
    send_item(32'haaaa_aaaa);
    send_item(32'h5555_5555);
    send_item(32'haaaa_aaa8);  // hit, other offset
    send_item(32'h0001_0000);  // lowest non-zero tag on line 0
    send_item(32'h8000_0002);  // top tag bit alone
    send_item(32'h8000_0000);  // hit

    // Sender pause: let every outstanding item drain before going on.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    foreach (hot_addr[i]) begin
      hot_addr[i] = $urandom();
    end
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      send_item(next_address());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (TAIL) @(posedge clk);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/dmc_pkg.sv
rtl/core/direct_mapped_cache_tag_check.sv
dv/direct_mapped_cache_tag_check_checker.sv
dv/direct_mapped_cache_tag_check_test.sv
